### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CSCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cscc assertion failed");
`define CSCC_ASSERT_NEVER(label, clk, rst_n, cond) \
    `CSCC_ASSERT(label, clk, rst_n, !(cond))
`else
`define CSCC_ASSERT(label, clk, rst_n, prop)
`define CSCC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

### rtl/cscc_pkg.sv
// shared types, codes and crc function of the container separator crc checker
package cscc_pkg;

    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = 2;
    localparam int FifoCntW  = 3;

    localparam logic [15:0] HeaderLengthReset = 16'd8;
    localparam logic [31:0] CrcPoly           = 32'hEDB8_8320;
    localparam logic [31:0] CrcInit           = 32'hFFFF_FFFF;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SEP    = 2'd1;
    localparam logic [1:0] PH_PART   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [2:0] ST_SEP_CHECKED  = 3'd0;
    localparam logic [2:0] ST_CLEAN_END    = 3'd1;
    localparam logic [2:0] ST_TRUNC_HEADER = 3'd2;
    localparam logic [2:0] ST_TRUNC_SEP    = 3'd3;
    localparam logic [2:0] ST_TRUNC_PART   = 3'd4;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] separator_number;
        logic [31:0] next_size;
        logic        crc_match;
        logic        is_terminator;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    typedef struct packed {
        logic [1:0] phase;
        logic [2:0] sep_index;
    } t_parse_stat;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/cscc_ifs.sv
// valid/ready channel interfaces: input bytes, results, configuration
interface cscc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_image;

    modport source (output valid, data_byte, end_of_image, input ready);
    modport sink (input valid, data_byte, end_of_image, output ready);
endinterface

interface cscc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] separator_number;
    logic [31:0] next_size;
    logic        crc_match;
    logic        is_terminator;
    logic        last_result;

    modport source (output valid, status, separator_number, next_size, crc_match,
                    is_terminator, last_result, input ready);
    modport sink (input valid, status, separator_number, next_size, crc_match,
                  is_terminator, last_result, output ready);
endinterface

interface cscc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] header_length;

    modport source (output valid, header_length, input ready);
    modport sink (input valid, header_length, output ready);
endinterface

### rtl/cscc_parser.sv
// parse state, running crc and result generation for one byte per cycle while i_accept is high
module cscc_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_image,
    input  logic [15:0]          i_header_length,
    output cscc_pkg::t_push      o_push,
    output cscc_pkg::t_parse_stat o_stat
);
    import cscc_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_brem, n_brem;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_size, n_size;
    logic [31:0] r_exp, n_exp;
    logic [31:0] r_rcv, n_rcv;
    logic [15:0] r_cnt, n_cnt;
    logic [31:0] r_crc, n_crc;

    logic        w_sep;
    logic        w_match;
    logic        w_term;
    logic [2:0]  w_end_status;
    t_result     w_sep_res;
    t_result     w_end_res;
    logic [31:0] w_hlen;

    assign w_hlen = {16'd0, i_header_length};

    always_comb begin
        n_phase = r_phase;
        n_brem  = r_brem;
        n_idx   = r_idx;
        n_size  = r_size;
        n_exp   = r_exp;
        n_rcv   = r_rcv;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        w_sep   = 1'b0;
        w_match = 1'b0;
        w_term  = 1'b0;

        // header already complete (zero length or register lowered)
        if (n_phase == PH_HEADER && n_brem >= w_hlen) begin
            n_phase = PH_SEP;
            n_brem  = '0;
            n_idx   = '0;
        end

        if (n_phase != PH_DONE) begin
            n_crc = crc_byte(r_crc, i_data_byte);
        end

        case (n_phase)
            PH_HEADER: begin
                n_brem = n_brem + 32'd1;
                if (n_brem >= w_hlen) begin
                    n_phase = PH_SEP;
                    n_brem  = '0;
                    n_idx   = '0;
                end
            end
            PH_SEP: begin
                if (!n_idx[2]) begin
                    if (n_idx[1:0] == 2'd0) begin
                        n_size = {24'd0, i_data_byte};
                    end else begin
                        n_size[{n_idx[1:0], 3'b000} +: 8] = i_data_byte;
                    end
                    if (n_idx[1:0] == 2'd3) begin
                        n_exp = ~n_crc;
                    end
                    n_idx = n_idx + 3'd1;
                end else begin
                    if (n_idx[1:0] == 2'd0) begin
                        n_rcv = {24'd0, i_data_byte};
                    end else begin
                        n_rcv[{n_idx[1:0], 3'b000} +: 8] = i_data_byte;
                    end
                    if (n_idx[1:0] == 2'd3) begin
                        w_sep   = 1'b1;
                        w_match = (n_rcv == n_exp);
                        w_term  = (n_size == 32'd0);
                        if (n_cnt != 16'hFFFF) begin
                            n_cnt = n_cnt + 16'd1;
                        end
                        n_idx = '0;
                        if (w_term) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_PART;
                            n_brem  = n_size;
                        end
                    end else begin
                        n_idx = n_idx + 3'd1;
                    end
                end
            end
            PH_PART: begin
                if (n_brem != 32'd0) begin
                    n_brem = n_brem - 32'd1;
                end
                if (n_brem == 32'd0) begin
                    n_phase = PH_SEP;
                    n_idx   = '0;
                end
            end
            default: begin
            end
        endcase

        case (n_phase)
            PH_DONE:   w_end_status = ST_CLEAN_END;
            PH_HEADER: w_end_status = ST_TRUNC_HEADER;
            PH_SEP:    w_end_status = (n_idx == 3'd0) ? ST_CLEAN_END : ST_TRUNC_SEP;
            default:   w_end_status = ST_TRUNC_PART;
        endcase

        w_sep_res.status           = ST_SEP_CHECKED;
        w_sep_res.separator_number = n_cnt;
        w_sep_res.next_size        = n_size;
        w_sep_res.crc_match        = w_match;
        w_sep_res.is_terminator    = w_term;
        w_sep_res.last_result      = !i_end_of_image;

        w_end_res.status           = w_end_status;
        w_end_res.separator_number = n_cnt;
        w_end_res.next_size        = '0;
        w_end_res.crc_match        = 1'b0;
        w_end_res.is_terminator    = 1'b0;
        w_end_res.last_result      = 1'b1;

        // image end: start over for the next image
        if (i_end_of_image) begin
            n_phase = PH_HEADER;
            n_brem  = '0;
            n_idx   = '0;
            n_size  = '0;
            n_exp   = '0;
            n_rcv   = '0;
            n_cnt   = '0;
            n_crc   = CrcInit;
        end

        o_push.count  = i_accept ? ({1'b0, w_sep} + {1'b0, i_end_of_image}) : 2'd0;
        o_push.first  = w_sep ? w_sep_res : w_end_res;
        o_push.second = w_end_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_brem  <= '0;
            r_idx   <= '0;
            r_size  <= '0;
            r_exp   <= '0;
            r_rcv   <= '0;
            r_cnt   <= '0;
            r_crc   <= CrcInit;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_brem  <= n_brem;
            r_idx   <= n_idx;
            r_size  <= n_size;
            r_exp   <= n_exp;
            r_rcv   <= n_rcv;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
        end
    end

    assign o_stat.phase     = r_phase;
    assign o_stat.sep_index = r_idx;

endmodule

### rtl/cscc_fifo.sv
// result queue taking up to two results per cycle and giving one per cycle while the sink is ready
module cscc_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cscc_pkg::t_push                   i_push,
    cscc_result_if.source                     o_result,
    output logic [cscc_pkg::FifoCntW-1:0]     o_count
);
    import cscc_pkg::*;

    t_result               r_mem [FifoDepth];
    logic [FifoPtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FifoPtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FifoCntW-1:0]   r_count, n_count;
    logic                  w_pop;
    logic [FifoPtrW-1:0]   w_wr_ptr1;
    t_result               w_head;

    assign w_pop     = o_result.valid && o_result.ready;
    assign w_wr_ptr1 = r_wr_ptr + FifoPtrW'(1);
    assign n_wr_ptr  = r_wr_ptr + FifoPtrW'(i_push.count);
    assign n_rd_ptr  = r_rd_ptr + FifoPtrW'(w_pop);
    assign n_count   = r_count + FifoCntW'(i_push.count) - FifoCntW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign w_head                    = r_mem[r_rd_ptr];
    assign o_result.valid            = (r_count != '0);
    assign o_result.status           = w_head.status;
    assign o_result.separator_number = w_head.separator_number;
    assign o_result.next_size        = w_head.next_size;
    assign o_result.crc_match        = w_head.crc_match;
    assign o_result.is_terminator    = w_head.is_terminator;
    assign o_result.last_result      = w_head.last_result;
    assign o_count                   = r_count;

endmodule

### rtl/container_separator_crc_checker.sv
// top level of the container separator crc checker
//
//  channel   | dir | payload                                            | item
//  i_byte    | in  | data_byte, end_of_image                            | one image byte
//  o_result  | out | status, separator_number, next_size, crc_match,    | one result
//            |     | is_terminator, last_result                         |
//  i_cfg     | in  | header_length                                      | one register write
//
//  a byte is parsed and its crc step done in the cycle it is taken: one byte per cycle
//  results leave a four-entry queue at one per cycle while o_result.ready is high; a byte ending both
//  a separator and the image gives two, and i_byte.ready drops while the queue holds more than two
//  synchronous active-low reset clears parse state, crc, queue and sets header_length to 8
//  i_cfg is always ready
`include "assert_macros.svh"

module container_separator_crc_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cscc_byte_if.sink      i_byte,
    cscc_result_if.source  o_result,
    cscc_cfg_if.sink       i_cfg
);
    import cscc_pkg::*;

    logic [15:0]          r_header_length;
    logic                 w_accept;
    t_push                w_push;
    t_parse_stat          w_stat;
    logic [FifoCntW-1:0]  w_count;
    logic                 w_eoi_taken;
    logic                 w_restarted;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = (w_count <= FifoCntW'(FifoDepth - 2));
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_eoi_taken  = w_accept && i_byte.end_of_image;
    assign w_restarted  = (w_stat.phase == PH_HEADER) && (w_stat.sep_index == 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_length <= HeaderLengthReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_header_length <= i_cfg.header_length;
        end
    end

    cscc_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_data_byte     (i_byte.data_byte),
        .i_end_of_image  (i_byte.end_of_image),
        .i_header_length (r_header_length),
        .o_push          (w_push),
        .o_stat          (w_stat)
    );

    cscc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_result (o_result),
        .o_count  (w_count)
    );

    `CSCC_ASSERT_NEVER(a_fifo_bound, i_clk, i_rst_n, w_count > FifoCntW'(FifoDepth))
    `CSCC_ASSERT(a_eoi_restart, i_clk, i_rst_n, w_eoi_taken |=> w_restarted)
    `CSCC_ASSERT(a_eoi_result, i_clk, i_rst_n, w_eoi_taken |=> o_result.valid)

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// testbench for the container separator crc checker: image stimulus, result prediction, checks
module testbench;
    import cscc_pkg::*;

    class separator_check_board;
        logic [15:0] header_len;
        logic [31:0] crc;
        logic [1:0]  phase;
        logic [31:0] remaining;
        logic [2:0]  sep_idx;
        logic [31:0] size_acc;
        logic [31:0] crc_want;
        logic [31:0] crc_stored;
        logic [15:0] sep_count;
        t_result     due_results[$];
        int          errors;

        function new();
            header_len = HeaderLengthReset;
            errors = 0;
            restart();
        endfunction

        function void restart();
            crc = CrcInit;
            phase = PH_HEADER;
            remaining = '0;
            sep_idx = '0;
            size_acc = '0;
            crc_want = '0;
            crc_stored = '0;
            sep_count = '0;
        endfunction

        static function logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
            logic [31:0] r;
            int i;
            r = c;
            for (i = 0; i < 8; i++) begin
                if (r[0] ^ b[i]) begin
                    r = {1'b0, r[31:1]} ^ CrcPoly;
                end else begin
                    r = {1'b0, r[31:1]};
                end
            end
            return r;
        endfunction

        function void take_byte(input logic [7:0] b, input logic eoi);
            t_result sep_res;
            t_result end_res;
            bit      have_sep;
            int      slot;
            have_sep = 1'b0;
            sep_res = '0;
            end_res = '0;
            if (phase == PH_HEADER && remaining >= {16'd0, header_len}) begin
                phase = PH_SEP;
                remaining = '0;
                sep_idx = '0;
            end
            if (phase != PH_DONE) crc = crc_next(crc, b);
            case (phase)
                PH_HEADER: begin
                    remaining++;
                    if (remaining >= {16'd0, header_len}) begin
                        phase = PH_SEP;
                        remaining = '0;
                        sep_idx = '0;
                    end
                end
                PH_SEP: begin
                    slot = int'(sep_idx);
                    if (slot < 4) begin
                        size_acc[8*slot +: 8] = b;
                        if (slot == 3) crc_want = ~crc;
                        sep_idx++;
                    end else begin
                        crc_stored[8*(slot-4) +: 8] = b;
                        if (slot == 7) begin
                            if (sep_count != 16'hFFFF) sep_count++;
                            have_sep = 1'b1;
                            sep_res.status = ST_SEP_CHECKED;
                            sep_res.separator_number = sep_count;
                            sep_res.next_size = size_acc;
                            sep_res.crc_match = (crc_stored == crc_want);
                            sep_res.is_terminator = (size_acc == '0);
                            sep_idx = '0;
                            if (size_acc == '0) begin
                                phase = PH_DONE;
                            end else begin
                                phase = PH_PART;
                                remaining = size_acc;
                            end
                        end else begin
                            sep_idx++;
                        end
                    end
                end
                PH_PART: begin
                    if (remaining != '0) remaining--;
                    if (remaining == '0) begin
                        phase = PH_SEP;
                        sep_idx = '0;
                    end
                end
                default: ;
            endcase
            if (eoi) begin
                end_res.separator_number = sep_count;
                case (phase)
                    PH_DONE:   end_res.status = ST_CLEAN_END;
                    PH_HEADER: end_res.status = ST_TRUNC_HEADER;
                    PH_SEP:    end_res.status = (sep_idx == '0) ? ST_CLEAN_END : ST_TRUNC_SEP;
                    default:   end_res.status = ST_TRUNC_PART;
                endcase
                end_res.last_result = 1'b1;
                restart();
            end else if (have_sep) begin
                sep_res.last_result = 1'b1;
            end
            if (have_sep) due_results.push_back(sep_res);
            if (eoi) due_results.push_back(end_res);
        endfunction

        function void match_field(input string label, input logic [31:0] want,
                                  input logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, label, want, got);
            end
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, got.status);
                return;
            end
            want = due_results.pop_front();
            match_field("status", 32'(want.status), 32'(got.status));
            match_field("separator_number", 32'(want.separator_number),
                        32'(got.separator_number));
            match_field("next_size", want.next_size, got.next_size);
            match_field("crc_match", 32'(want.crc_match), 32'(got.crc_match));
            match_field("is_terminator", 32'(want.is_terminator),
                        32'(got.is_terminator));
            match_field("last_result", 32'(want.last_result), 32'(got.last_result));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cscc_byte_if   byte_ch();
    cscc_result_if res_ch();
    cscc_cfg_if    cfg_ch();

    container_separator_crc_checker u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_byte   (byte_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    separator_check_board board = new();
    t_result     seen;
    logic [31:0] stream_crc = CrcInit;
    int          cur_hlen = 8;
    int          cut_countdown = 0;
    bit          image_ended = 1'b0;
    bit          steady = 1'b0;
    int          hold_request = 0;
    int          sent_count = 0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int idle_span();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) board.header_len = cfg_ch.header_length;
            if (byte_ch.valid && byte_ch.ready)
                board.take_byte(byte_ch.data_byte, byte_ch.end_of_image);
            if (res_ch.valid && res_ch.ready) begin
                seen.status = res_ch.status;
                seen.separator_number = res_ch.separator_number;
                seen.next_size = res_ch.next_size;
                seen.crc_match = res_ch.crc_match;
                seen.is_terminator = res_ch.is_terminator;
                seen.last_result = res_ch.last_result;
                board.check_result(seen);
            end
        end
    end

    // result side: random stalls, plus a long hold on request
    initial begin
        int hold_len;
        int gap;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                res_ch.ready <= 1'b0;
                hold_len = hold_request;
                hold_request = 0;
                repeat (hold_len) @(negedge clk);
            end else if (steady || $urandom_range(0, 99) < 65) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b0;
                gap = idle_span();
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        if (image_ended) return;
        if (cut_countdown > 0) begin
            cut_countdown--;
            if (cut_countdown == 0) begin
                eoi = 1'b1;
                image_ended = 1'b1;
            end
        end
        gap = (!steady && $urandom_range(0, 99) < 25) ? idle_span() : 0;
        @(negedge clk);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.end_of_image <= eoi;
        do @(posedge clk); while (!byte_ch.ready);
        sent_count++;
        stream_crc = eoi ? CrcInit : separator_check_board::crc_next(stream_crc, b);
    endtask

    task automatic send_separator(input logic [31:0] size, input bit bad, input bit eoi_last);
        logic [31:0] stored;
        int k;
        for (k = 0; k < 4; k++) send_byte(size[8*k +: 8], 1'b0);
        stored = ~stream_crc;
        if (bad) stored = stored ^ (32'd1 << $urandom_range(0, 31));
        for (k = 0; k < 4; k++) send_byte(stored[8*k +: 8], eoi_last && k == 3);
    endtask

    task automatic send_container(input int parts, input int max_part, input int trailing,
                                  input int cut, input bit wide);
        logic [31:0] sz;
        int p;
        int k;
        int span;
        bit ended;
        cut_countdown = cut;
        image_ended = 1'b0;
        ended = 1'b0;
        for (k = 0; k < cur_hlen; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        for (p = 0; p < parts && !ended; p++) begin
            sz = (wide && p == 0) ? $urandom : $urandom_range(1, max_part);
            send_separator(sz, $urandom_range(0, 9) == 0, 1'b0);
            span = (sz > 48) ? 48 : sz;
            for (k = 0; k < span; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
            if (sz > 48) begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
                ended = 1'b1;
            end
        end
        if (!ended) begin
            send_separator(32'd0, $urandom_range(0, 9) == 0, trailing == 0);
            for (k = 0; k < trailing; k++)
                send_byte(8'($urandom_range(0, 255)), k == trailing - 1);
        end
        cut_countdown = 0;
        image_ended = 1'b0;
    endtask

    task automatic send_garbage(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_byte(8'($urandom_range(0, 255)), k == n - 1 || $urandom_range(0, 7) == 0);
    endtask

    task automatic drain_results();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_header_length(input logic [15:0] value);
        drain_results();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.header_length <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_hlen = int'(value);
    endtask

    initial begin
        int k;
        int ph;
        int pick;
        int target;
        logic [15:0] hl;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.end_of_image = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.header_length = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // header length at its reset value, image ends inside the header
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        write_header_length(16'd0);
        send_separator(32'd1, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_separator(32'd0, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_separator(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_byte(8'h80, 1'b1);

        // header length lowered below the bytes already taken
        write_header_length(16'd8);
        for (k = 0; k < 5; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        write_header_length(16'd3);
        send_separator(32'd2, 1'b0, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);

        write_header_length(16'hFFFF);
        send_container(1, 4, 0, 30, 1'b0);

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: hl = 16'd5;
                1: hl = 16'd0;
                2: hl = 16'd1;
                3: hl = 16'd12;
                4: hl = 16'($urandom_range(2, 10));
                default: hl = 16'd8;
            endcase
            write_header_length(hl);
            if (ph == 2) begin
                hold_request = 300;
                steady = 1'b1;
                send_container(12, 1, 0, 0, 1'b0);
                steady = 1'b0;
            end
            target = sent_count + 220;
            while (sent_count < target) begin
                steady = ($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_container($urandom_range(0, 4), $urandom_range(1, 12),
                                   $urandom_range(0, 3),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0,
                                   1'b0);
                end else if (pick < 80) begin
                    send_container(1, 8, 0, 0, 1'b1);
                end else begin
                    send_garbage($urandom_range(1, 20));
                end
            end
            steady = 1'b0;
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.due_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/cscc_pkg.sv
rtl/cscc_ifs.sv
rtl/cscc_parser.sv
rtl/cscc_fifo.sv
rtl/container_separator_crc_checker.sv
test/testbench.sv
